[rtl/core/rmq_pkg.sv]
// shared types, constants and step functions for the rotation matrix to quaternion pipeline
// used by every module of the block, depends on nothing
package rmq_pkg;

    localparam int unsigned DataW  = 16;
    localparam int unsigned MagW   = 17;   // magnitude of an off-diagonal sum or difference
    localparam int unsigned RadW   = 17;   // positive radicand, raw Q14
    localparam int unsigned RootW  = 16;
    localparam int unsigned NumSt  = 10;   // prep, 4 root, 4 divide, output
    localparam int unsigned SqSt   = 4;
    localparam int unsigned DvSt   = 4;
    localparam int unsigned QBits  = 15;   // quotient bits below the overflow point

    // which quaternion component comes from the root
    localparam logic [1:0] PICK_W = 2'd0;
    localparam logic [1:0] PICK_X = 2'd1;
    localparam logic [1:0] PICK_Y = 2'd2;
    localparam logic [1:0] PICK_Z = 2'd3;

    localparam logic signed [DataW-1:0] SAT_POS = 16'sh7fff;
    localparam logic signed [DataW-1:0] SAT_NEG = 16'sh8000;

    // context from prep to the divide stages; lane n is the n-th component not picked
    typedef struct packed {
        logic            degen;
        logic [1:0]      pick;
        logic [2:0]      neg;
        logic [MagW-1:0] mag0;
        logic [MagW-1:0] mag1;
        logic [MagW-1:0] mag2;
    } t_ctx;

    // context from the root to the output stage
    typedef struct packed {
        logic             degen;
        logic [1:0]       pick;
        logic [2:0]       neg;
        logic [RootW-2:0] half;
    } t_post;

    // digit-by-digit square root state
    typedef struct packed {
        logic [31:0] x;
        logic [17:0] rem;
        logic [15:0] root;
    } t_sq;

    // restoring divider state
    typedef struct packed {
        logic [QBits-1:0] lo;
        logic [16:0]      rem;
        logic [16:0]      v;
        logic [QBits-1:0] q;
        logic             ovf;
    } t_dv;

    // one root bit from the next two radicand bits
    function automatic t_sq sqrt_step(input t_sq s);
        t_sq         o;
        logic [19:0] r;
        logic [19:0] trial;
        o     = s;
        r     = {s.rem, s.x[31:30]};
        trial = {2'b00, s.root, 2'b01};
        if (r >= trial) begin
            r      = r - trial;
            o.root = {s.root[14:0], 1'b1};
        end else begin
            o.root = {s.root[14:0], 1'b0};
        end
        o.rem = r[17:0];
        o.x   = {s.x[29:0], 2'b00};
        return o;
    endfunction

    // one quotient bit
    function automatic t_dv div_step(input t_dv s);
        t_dv         o;
        logic [17:0] r;
        o  = s;
        r  = {s.rem, s.lo[QBits-1]};
        if (r >= {1'b0, s.v}) begin
            r   = r - {1'b0, s.v};
            o.q = {s.q[QBits-2:0], 1'b1};
        end else begin
            o.q = {s.q[QBits-2:0], 1'b0};
        end
        o.rem = r[16:0];
        o.lo  = {s.lo[QBits-2:0], 1'b0};
        return o;
    endfunction

endpackage

[rtl/core/rmq_prep.sv]
// first pipeline stage: trace, axis pick, radicand and off-diagonal terms
// depends on rmq_pkg
module rmq_prep (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [143:0]                i_data,  // m00 m01 m02 m10 m11 m12 m20 m21 m22
    output rmq_pkg::t_ctx               o_ctx,
    output logic [rmq_pkg::RadW-1:0]    o_rad
);
    import rmq_pkg::*;

    logic signed [15:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
    logic signed [18:0] tr;
    logic signed [18:0] rad;
    logic signed [17:0] n0, n1, n2;
    logic signed [15:0] mii;
    logic [1:0]         ax;
    logic [1:0]         pick;
    t_ctx               n_ctx;
    t_ctx               r_ctx;
    logic [RadW-1:0]    r_rad;

    function automatic logic [MagW-1:0] mag_of(input logic signed [17:0] n);
        logic signed [17:0] a;
        a = n[17] ? -n : n;
        return a[MagW-1:0];
    endfunction

    assign a00 = i_data[15:0];
    assign a01 = i_data[31:16];
    assign a02 = i_data[47:32];
    assign a10 = i_data[63:48];
    assign a11 = i_data[79:64];
    assign a12 = i_data[95:80];
    assign a20 = i_data[111:96];
    assign a21 = i_data[127:112];
    assign a22 = i_data[143:128];

    assign tr = 19'(a00) + 19'(a11) + 19'(a22);

    // largest diagonal entry, earlier axis wins ties
    always_comb begin
        ax  = 2'd0;
        mii = a00;
        if (a11 > a00) begin
            ax  = 2'd1;
            mii = a11;
        end
        if (a22 > mii) begin
            ax = 2'd2;
        end
    end

    // radicand and the three other terms in component order
    always_comb begin
        if (tr > 19'sd0) begin
            pick = PICK_W;
            rad  = tr + 19'sd16384;
            n0   = 18'(a21) - 18'(a12);
            n1   = 18'(a02) - 18'(a20);
            n2   = 18'(a10) - 18'(a01);
        end else begin
            unique case (ax)
                2'd1: begin
                    pick = PICK_Y;
                    rad  = 19'(a11) - 19'(a22) - 19'(a00) + 19'sd16384;
                    n0   = 18'(a02) - 18'(a20);
                    n1   = 18'(a01) + 18'(a10);
                    n2   = 18'(a21) + 18'(a12);
                end
                2'd2: begin
                    pick = PICK_Z;
                    rad  = 19'(a22) - 19'(a00) - 19'(a11) + 19'sd16384;
                    n0   = 18'(a10) - 18'(a01);
                    n1   = 18'(a02) + 18'(a20);
                    n2   = 18'(a12) + 18'(a21);
                end
                default: begin
                    pick = PICK_X;
                    rad  = 19'(a00) - 19'(a11) - 19'(a22) + 19'sd16384;
                    n0   = 18'(a21) - 18'(a12);
                    n1   = 18'(a10) + 18'(a01);
                    n2   = 18'(a20) + 18'(a02);
                end
            endcase
        end
        n_ctx.degen = (rad <= 19'sd0);
        n_ctx.pick  = pick;
        n_ctx.neg   = {n2[17], n1[17], n0[17]};
        n_ctx.mag0  = mag_of(n0);
        n_ctx.mag1  = mag_of(n1);
        n_ctx.mag2  = mag_of(n2);
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctx <= n_ctx;
            r_rad <= n_ctx.degen ? '0 : rad[RadW-1:0];
        end
    end

    assign o_ctx = r_ctx;
    assign o_rad = r_rad;

endmodule

[rtl/core/rmq_isqrt.sv]
// pipelined integer square root of radicand * 16384, four bits per stage
// depends on rmq_pkg; carries the prep context alongside
module rmq_isqrt (
    input  logic                       i_clk,
    input  logic [rmq_pkg::SqSt-1:0]   i_en,
    input  logic [rmq_pkg::RadW-1:0]   i_rad,
    input  rmq_pkg::t_ctx              i_ctx,
    output logic [rmq_pkg::RootW-1:0]  o_root,
    output rmq_pkg::t_ctx              o_ctx
);
    import rmq_pkg::*;

    t_sq  r_sq  [SqSt];
    t_ctx r_ctx [SqSt];
    t_sq  n_sq  [SqSt];
    t_sq  s_in  [SqSt];

    // stage inputs
    always_comb begin
        s_in[0].x    = {1'b0, i_rad, 14'b0};
        s_in[0].rem  = '0;
        s_in[0].root = '0;
        for (int k = 1; k < SqSt; k++) begin
            s_in[k] = r_sq[k-1];
        end
    end

    // four root bits per stage
    always_comb begin
        for (int k = 0; k < SqSt; k++) begin
            n_sq[k] = sqrt_step(sqrt_step(sqrt_step(sqrt_step(s_in[k]))));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SqSt; k++) begin
            if (i_en[k]) begin
                r_sq[k]  <= n_sq[k];
                r_ctx[k] <= (k == 0) ? i_ctx : r_ctx[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign o_root = r_sq[SqSt-1].root;
    assign o_ctx  = r_ctx[SqSt-1];

endmodule

[rtl/core/rmq_div.sv]
// one divider lane: (mag * 16384 + root) / (2 * root), overflow at 32768
// depends on rmq_pkg; 15 quotient bits over four stages
module rmq_div (
    input  logic                        i_clk,
    input  logic [rmq_pkg::DvSt-1:0]    i_en,
    input  logic [rmq_pkg::MagW-1:0]    i_mag,
    input  logic [rmq_pkg::RootW-1:0]   i_root,
    output logic [rmq_pkg::QBits-1:0]   o_q,
    output logic                        o_ovf
);
    import rmq_pkg::*;

    t_dv         r_dv [DvSt];
    t_dv         n_dv [DvSt];
    t_dv         s0;
    logic [30:0] dvd;

    // dividend, divisor and the overflow check
    always_comb begin
        dvd    = {i_mag, 14'b0} + 31'(i_root);
        s0.v   = {i_root, 1'b0};
        s0.rem = {1'b0, dvd[30:15]};
        s0.lo  = dvd[14:0];
        s0.q   = '0;
        s0.ovf = ({1'b0, dvd[30:15]} >= {i_root, 1'b0});
    end

    // three bits in the first stage, four after
    always_comb begin
        n_dv[0] = div_step(div_step(div_step(s0)));
        for (int k = 1; k < DvSt; k++) begin
            n_dv[k] = div_step(div_step(div_step(div_step(r_dv[k-1]))));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DvSt; k++) begin
            if (i_en[k]) begin
                r_dv[k] <= n_dv[k];
            end
        end
    end

    assign o_q   = r_dv[DvSt-1].q;
    assign o_ovf = r_dv[DvSt-1].ovf;

endmodule

[rtl/core/rotation_matrix_to_quaternion.sv]
// Converts one 3x3 rotation matrix (Q2.14) to a quaternion (Q2.14) per beat.
// Fully pipelined: a new matrix can be taken every clock cycle while the
// output is not stalled. The depth is set by the 16-step square root and the
// 15-step restoring divide, each spread over four register stages, plus one
// prep and one output stage. A stalled output holds back the pipeline only as
// far as there are no empty stages to fill. Inputs whose radicand is not
// positive give a zero quaternion with the degenerate flag in tuser set.
// top level; depends on rmq_pkg, rmq_prep, rmq_isqrt, rmq_div
module rotation_matrix_to_quaternion (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [143:0]  i_s_axis_tdata,   // m00 m01 m02 m10 m11 m12 m20 m21 m22
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [63:0]   o_m_axis_tdata,   // qw qx qy qz
    output logic          o_m_axis_tuser    // degenerate
);
    import rmq_pkg::*;

    localparam int unsigned StSq = 1;
    localparam int unsigned StDv = StSq + SqSt;
    localparam int unsigned StOut = StDv + DvSt;

    logic [NumSt-1:0]     r_vld;
    logic [NumSt-1:0]     en;
    t_ctx                 ctx_p;
    t_ctx                 ctx_s;
    logic [RadW-1:0]      rad_p;
    logic [RootW-1:0]     root_s;
    t_post                post_in;
    t_post                r_post [DvSt];
    logic [QBits-1:0]     q_l   [3];
    logic [2:0]           ovf_l;
    logic [DataW-1:0]     v_l   [3];
    logic [63:0]          n_data;
    logic [63:0]          r_data;
    logic                 r_user;

    // stage enables: a stage loads when empty or when the next one moves
    always_comb begin
        en[NumSt-1] = !r_vld[NumSt-1] || i_m_axis_tready;
        for (int k = NumSt-2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NumSt; k++) begin
                if (en[k]) begin
                    r_vld[k] <= (k == 0) ? i_s_axis_tvalid : r_vld[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    rmq_prep u_prep (
        .i_clk  (i_clk),
        .i_en   (en[0]),
        .i_data (i_s_axis_tdata),
        .o_ctx  (ctx_p),
        .o_rad  (rad_p)
    );

    rmq_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en[StDv-1:StSq]),
        .i_rad  (rad_p),
        .i_ctx  (ctx_p),
        .o_root (root_s),
        .o_ctx  (ctx_s)
    );

    rmq_div u_div0 (
        .i_clk  (i_clk),
        .i_en   (en[StOut-1:StDv]),
        .i_mag  (ctx_s.mag0),
        .i_root (root_s),
        .o_q    (q_l[0]),
        .o_ovf  (ovf_l[0])
    );

    rmq_div u_div1 (
        .i_clk  (i_clk),
        .i_en   (en[StOut-1:StDv]),
        .i_mag  (ctx_s.mag1),
        .i_root (root_s),
        .o_q    (q_l[1]),
        .o_ovf  (ovf_l[1])
    );

    rmq_div u_div2 (
        .i_clk  (i_clk),
        .i_en   (en[StOut-1:StDv]),
        .i_mag  (ctx_s.mag2),
        .i_root (root_s),
        .o_q    (q_l[2]),
        .o_ovf  (ovf_l[2])
    );

    // side context through the divide stages
    always_comb begin
        post_in.degen = ctx_s.degen;
        post_in.pick  = ctx_s.pick;
        post_in.neg   = ctx_s.neg;
        post_in.half  = root_s[RootW-1:1];
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DvSt; k++) begin
            if (en[StDv+k]) begin
                r_post[k] <= (k == 0) ? post_in : r_post[(k == 0) ? 0 : k-1];
            end
        end
    end

    // sign and saturation per lane
    always_comb begin
        for (int n = 0; n < 3; n++) begin
            if (ovf_l[n]) begin
                v_l[n] = r_post[DvSt-1].neg[n] ? SAT_NEG : SAT_POS;
            end else if (r_post[DvSt-1].neg[n]) begin
                v_l[n] = -{1'b0, q_l[n]};
            end else begin
                v_l[n] = {1'b0, q_l[n]};
            end
        end
    end

    // place the root half and the three lanes
    always_comb begin
        if (r_post[DvSt-1].degen) begin
            n_data = '0;
        end else begin
            unique case (r_post[DvSt-1].pick)
                PICK_W:  n_data = {v_l[2], v_l[1], v_l[0], {1'b0, r_post[DvSt-1].half}};
                PICK_X:  n_data = {v_l[2], v_l[1], {1'b0, r_post[DvSt-1].half}, v_l[0]};
                PICK_Y:  n_data = {v_l[2], {1'b0, r_post[DvSt-1].half}, v_l[1], v_l[0]};
                default: n_data = {{1'b0, r_post[DvSt-1].half}, v_l[2], v_l[1], v_l[0]};
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (en[StOut]) begin
            r_data <= n_data;
            r_user <= r_post[DvSt-1].degen;
        end
    end

    assign o_s_axis_tready = en[0];
    assign o_m_axis_tvalid = r_vld[StOut];
    assign o_m_axis_tdata  = r_data;
    assign o_m_axis_tuser  = r_user;

    // degenerate beats carry a zero quaternion
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == 64'd0)
        else $error("degenerate beat with nonzero quaternion");

    // a positive radicand gives a nonzero root
    a_root_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[StDv-1] && !ctx_s.degen |-> root_s != '0)
        else $error("zero root on a valid radicand");

    // the trace path never flags degenerate
    a_trace_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] && ctx_p.pick == PICK_W |-> !ctx_p.degen)
        else $error("trace path marked degenerate");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule
